// ===== hw/rtl/rescl_pkg.sv =====
// Shared types and constants for the row edge scan centerline block.
// Used by the lane, merge, top level and checker modules.
`default_nettype none

package rescl_pkg;

	// Row geometry
	localparam int PIX_CNT  = 80;
	localparam int PIX_LAST = 79;
	localparam int PIX_MID  = 39;
	localparam int POS_W    = 7;
	localparam int HW_W     = 6;
	localparam int ROW_W    = 6;
	localparam int ROWS_DEF = 60;

	// Pixel words on the input beat: head holds pixels 0..63, tail 64..79
	localparam int HEAD_W   = 64;
	localparam int TAIL_W   = 16;

	// Lane split: LANE_CNT lanes of LANE_W pixels cover the whole row
	localparam int LANE_CNT = 8;
	localparam int LANE_W   = 10;

	// Stream widths
	localparam int S_TDATA_W = 88;
	localparam int M_TDATA_W = 16;

	// What one lane found in its pixel segment
	typedef struct packed {
		logic             at_s;
		logic             r_hit;
		logic [POS_W-1:0] r_pos;
		logic             l_hit;
		logic [POS_W-1:0] l_pos;
	} lane_res_t;

	// Merged edges and the resulting centre
	typedef struct packed {
		logic             lfound;
		logic             rfound;
		logic             both;
		logic [POS_W-1:0] mid;
		logic [HW_W-1:0]  hw_new;
	} edge_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rescl_lane.sv =====
// One scan lane: nearest black pixel right and left of the start column
// inside a segment of the row. Depends on rescl_pkg.
`default_nettype none

module rescl_lane (
	input  wire logic [rescl_pkg::LANE_W-1:0] seg,
	input  wire logic [rescl_pkg::POS_W-1:0]  base,
	input  wire logic [rescl_pkg::POS_W-1:0]  s,
	output rescl_pkg::lane_res_t              res
);
	import rescl_pkg::*;

	logic [POS_W-1:0] gpos [LANE_W];

	// Global column of each pixel in the segment
	always_comb begin
		for (int i = 0; i < LANE_W; i++) begin
			gpos[i] = base + POS_W'(i);
		end
	end

	// Pick lowest black column above s, highest below s, and flag s itself
	always_comb begin
		res = '0;
		for (int i = LANE_W - 1; i >= 0; i--) begin
			if (seg[i] && (gpos[i] > s)) begin
				res.r_hit = 1'b1;
				res.r_pos = gpos[i];
			end
		end
		for (int i = 0; i < LANE_W; i++) begin
			if (seg[i] && (gpos[i] < s)) begin
				res.l_hit = 1'b1;
				res.l_pos = gpos[i];
			end
			if (seg[i] && (gpos[i] == s)) begin
				res.at_s = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rescl_merge.sv =====
// Merge of the lane results: edge selection, lost-edge rebuild, midpoint
// and half width. Depends on rescl_pkg.
`default_nettype none

module rescl_merge (
	input  wire rescl_pkg::lane_res_t          lanes [rescl_pkg::LANE_CNT],
	input  wire logic [rescl_pkg::HW_W-1:0]    hw,
	output rescl_pkg::edge_res_t               res
);
	import rescl_pkg::*;

	logic             at_s;
	logic             r_any;
	logic             l_any;
	logic [POS_W-1:0] r_pos;
	logic [POS_W-1:0] l_pos;
	logic signed [9:0] l_e;
	logic signed [9:0] r_e;
	logic signed [9:0] dbl;
	logic signed [9:0] sum;
	logic signed [9:0] diff;
	logic [8:0]        half;

	// Lowest lane wins on the right, highest lane wins on the left
	always_comb begin
		at_s  = 1'b0;
		r_any = 1'b0;
		l_any = 1'b0;
		r_pos = '0;
		l_pos = '0;
		for (int k = LANE_CNT - 1; k >= 0; k--) begin
			if (lanes[k].r_hit) begin
				r_any = 1'b1;
				r_pos = lanes[k].r_pos;
			end
		end
		for (int k = 0; k < LANE_CNT; k++) begin
			if (lanes[k].l_hit) begin
				l_any = 1'b1;
				l_pos = lanes[k].l_pos;
			end
			at_s = at_s | lanes[k].at_s;
		end
	end

	// Edges at the border columns or a black start pixel count as lost
	always_comb begin
		res.rfound = !at_s && r_any && (r_pos != POS_W'(PIX_LAST));
		res.lfound = !at_s && l_any && (l_pos != '0);
		res.both   = res.rfound && res.lfound;
	end

	// Rebuild a lost edge from the other one and twice the half width; with both lost, span 0..79
	always_comb begin
		dbl = signed'({3'b000, hw, 1'b0});
		priority if (res.lfound && res.rfound) begin
			l_e = signed'({3'b000, l_pos});
			r_e = signed'({3'b000, r_pos});
		end else if (res.rfound) begin
			r_e = signed'({3'b000, r_pos});
			l_e = r_e - dbl;
		end else if (res.lfound) begin
			l_e = signed'({3'b000, l_pos});
			r_e = l_e + dbl;
		end else begin
			l_e = '0;
			r_e = 10'(PIX_LAST);
		end
	end

	// Truncated midpoint, clamped to the row
	always_comb begin
		sum  = l_e + r_e;
		diff = r_e - l_e;
		half = sum[9:1];
		priority if (sum < 0) begin
			res.mid = '0;
		end else if (half > 9'(PIX_LAST)) begin
			res.mid = POS_W'(PIX_LAST);
		end else begin
			res.mid = half[POS_W-1:0];
		end
		res.hw_new = diff[HW_W:1];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/row_edge_scan_centerline_top.sv =====
// Top level of the row edge scan centerline block: row table memory,
// scan lanes, merge stage and output register. Depends on rescl_pkg,
// rescl_lane and rescl_merge.
//
// Usage: one input beat on s_* carries a binarized 80-pixel row and its
// row number; one output beat on m_* carries the track centre, the
// steering error and both edge-found flags for that row. Each row has
// an entry in a table of last centre and last half width; a row number at
// or beyond ROWS reads centre 39 and half width 39 and writes nothing.
// An accepted beat is captured in stage 1, its lane results in stage 2,
// and it loads the output register when free. One row is in flight at a
// time: the table read-modify-write spans the accept edge, one lane stage
// and the merge stage, so no beat is taken until the row leaves stage 2.
// While the receiver stalls, a finished result holds in the output
// register; one more row may be accepted and then waits in the merge
// stage, and s_tready stays low until it moves on.
// Reset: arst_n clears the pipeline, the output valid bit and the table
// valid bits, so every row reads 39/39 until first written; no clearing
// pass is needed. The first row after reset scans from column 39 with a
// half width of zero.
`default_nettype none

module row_edge_scan_centerline_top #(
	parameter int ROWS = rescl_pkg::ROWS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// [5:0] row_index, [69:6] pixels_head, [85:70] pixels_tail, [87:86] zero
	input  wire logic [rescl_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [6:0] centre, [13:7] steering_error, [14] left_found, [15] right_found
	output logic [rescl_pkg::M_TDATA_W-1:0]       m_tdata
);
	import rescl_pkg::*;

	localparam int IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ENT_W = POS_W + HW_W;

	// Memory of row entries: {centre, half width}
	logic [ENT_W-1:0] mem [ROWS];
	logic [ROWS-1:0]  vld_q;
	logic             started_q;

	// Stage 1: captured row and table read
	logic                v_s1;
	logic [ROW_W-1:0]    row_s1;
	logic [PIX_CNT-1:0]  pixw_s1;
	logic [ENT_W-1:0]    rd_s1;
	logic                vld_s1;

	// Stage 2: lane results
	logic                v_s2;
	lane_res_t           lanes_s2 [LANE_CNT];
	logic [HW_W-1:0]     hw_s2;
	logic [HW_W-1:0]     keep_hw_s2;
	logic [IDX_W-1:0]    idx_s2;
	logic                wr_s2;

	logic                s_acc;
	logic                adv_s2;
	logic [IDX_W-1:0]    in_idx;
	logic                in_range;
	logic                first;
	logic [POS_W-1:0]    tab_c;
	logic [HW_W-1:0]     tab_h;
	logic [POS_W-1:0]    scan_s;
	logic [HW_W-1:0]     scan_hw;
	logic [PIX_CNT-1:0]  pix;
	lane_res_t           lanes [LANE_CNT];
	edge_res_t           eres;
	logic [POS_W-1:0]    err;

	// Handshake: one row in flight through the two internal stages
	assign s_tready = !v_s1 && !v_s2;
	assign s_acc    = s_tvalid && s_tready;
	assign adv_s2   = v_s2 && (!m_tvalid || m_tready);
	assign in_idx   = s_tdata[IDX_W-1:0];

	// Read the row entry on the accept edge; keep pixel 0 in the top bit; write back on stage 2 advance
	always_ff @(posedge clk) begin
		if (s_acc) begin
			rd_s1   <= mem[in_idx];
			row_s1  <= s_tdata[ROW_W-1:0];
			pixw_s1 <= {s_tdata[ROW_W +: HEAD_W], s_tdata[ROW_W + HEAD_W +: TAIL_W]};
		end
		if (adv_s2 && wr_s2) begin
			mem[idx_s2] <= {eres.mid, eres.both ? eres.hw_new : keep_hw_s2};
		end
	end

	// Valid bits and the started flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			vld_s1    <= 1'b0;
			started_q <= 1'b0;
		end else begin
			if (s_acc) begin
				vld_s1 <= vld_q[in_idx];
			end
			if (v_s1) begin
				started_q <= 1'b1;
			end
			if (adv_s2 && wr_s2) begin
				vld_q[idx_s2] <= 1'b1;
			end
		end
	end

	// Pick the scan start and half width for this row
	always_comb begin
		in_range = {1'b0, row_s1} < (ROW_W + 1)'(ROWS);
		first    = !started_q;
		tab_c    = vld_s1 ? rd_s1[ENT_W-1:HW_W] : POS_W'(PIX_MID);
		tab_h    = vld_s1 ? rd_s1[HW_W-1:0] : HW_W'(PIX_MID);
		priority if (first) begin
			scan_s  = POS_W'(PIX_MID);
			scan_hw = '0;
		end else if (in_range) begin
			scan_s  = (tab_c > POS_W'(PIX_LAST)) ? POS_W'(PIX_LAST) : tab_c;
			scan_hw = tab_h;
		end else begin
			scan_s  = POS_W'(PIX_MID);
			scan_hw = HW_W'(PIX_MID);
		end
	end

	// Reorder so that bit p is pixel p
	always_comb begin
		for (int p = 0; p < PIX_CNT; p++) begin
			pix[p] = pixw_s1[PIX_LAST - p];
		end
	end

	// Scan lanes, one per pixel segment
	for (genvar l = 0; l < LANE_CNT; l++) begin : g_lane
		rescl_lane u_lane (
			.seg  (pix[l*LANE_W +: LANE_W]),
			.base (POS_W'(l * LANE_W)),
			.s    (scan_s),
			.res  (lanes[l])
		);
	end

	// Stage 1 and stage 2 valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= s_acc;
			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (adv_s2) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			lanes_s2   <= lanes;
			hw_s2      <= scan_hw;
			keep_hw_s2 <= tab_h;
			idx_s2     <= row_s1[IDX_W-1:0];
			wr_s2      <= in_range;
		end
	end

	rescl_merge u_merge (
		.lanes (lanes_s2),
		.hw    (hw_s2),
		.res   (eres)
	);

	assign err = eres.mid - POS_W'(PIX_MID);

	// Output register: load on advance, drop on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv_s2) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			m_tdata <= {eres.rfound, eres.lfound, err, eres.mid};
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rescl_chk.sv =====
// Port-level checker for the row edge scan centerline top level and the
// bind that attaches it. Depends on rescl_pkg.
`default_nettype none

module rescl_chk (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_tvalid,
	input wire logic                             s_tready,
	input wire logic                             m_tvalid,
	input wire logic                             m_tready,
	input wire logic [rescl_pkg::M_TDATA_W-1:0]  m_tdata
);
	import rescl_pkg::*;

	// Hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output beat changed");

	// One row in flight: no accept right after an accept
	a_one_row: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a row is in flight");

	// Output valid after an accept and both internal stages: this row or a stalled older one
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##3 m_tvalid)
		else $error("no result three cycles after accept");

	// Centre stays on the row
	a_centre: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[6:0] <= 7'(PIX_LAST))
		else $error("centre beyond last column");

	// Steering error tracks the centre
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[13:7] == 7'(m_tdata[6:0] - 7'(PIX_MID)))
		else $error("steering error does not match centre");

endmodule

bind row_edge_scan_centerline_top rescl_chk u_rescl_chk (.*);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for row_edge_scan_centerline_top: drives binarized rows with
// random bursts and stalls and checks every output beat against a row-table scan
// predictor. Depends on rescl_pkg and the top-level RTL only.
`default_nettype none

// Scan predictor and queue of centre results still owed by the block
class row_scan_scoreboard;
	typedef struct {
		bit [6:0] centre;
		bit [6:0] steer;
		bit       left_found;
		bit       right_found;
	} centre_result_t;

	bit                                 started;
	bit [rescl_pkg::POS_W-1:0]          centre_tab[rescl_pkg::ROWS_DEF];
	bit [rescl_pkg::HW_W-1:0]           halfw_tab[rescl_pkg::ROWS_DEF];
	centre_result_t                     results_due[$];
	int                                 mismatches;
	int                                 beats_seen;

	function new();
		started     = 1'b0;
		mismatches  = 0;
		beats_seen  = 0;
		foreach (centre_tab[i]) begin
			centre_tab[i] = 7'(rescl_pkg::PIX_MID);
			halfw_tab[i]  = 6'(rescl_pkg::PIX_MID);
		end
	endfunction

	function int pending();
		return results_due.size();
	endfunction

	// Scan one accepted row and queue the centre it must produce
	function void note_row(bit [5:0] row, bit [79:0] pix);
		int             s, hw, p, lft, rgt, sum, mid;
		bit             lf, rf, in_rng;
		centre_result_t want;
		in_rng = row < rescl_pkg::ROWS_DEF;
		if (!started) begin
			started = 1'b1;
			foreach (centre_tab[i]) begin
				centre_tab[i] = 7'(rescl_pkg::PIX_MID);
				halfw_tab[i]  = 6'(rescl_pkg::PIX_MID);
			end
			s  = rescl_pkg::PIX_MID;
			hw = 0;
		end else if (in_rng) begin
			s  = centre_tab[row];
			hw = halfw_tab[row];
		end else begin
			s  = rescl_pkg::PIX_MID;
			hw = rescl_pkg::PIX_MID;
		end
		if (s > rescl_pkg::PIX_LAST)
			s = rescl_pkg::PIX_LAST;

		// Pixel p lives at bit 79-p; a black start pixel loses both edges
		lft = 0;
		rgt = rescl_pkg::PIX_LAST;
		lf  = 1'b0;
		rf  = 1'b0;
		if (!pix[rescl_pkg::PIX_LAST - s]) begin
			for (p = s + 1; p <= rescl_pkg::PIX_LAST; p++) begin
				if (pix[rescl_pkg::PIX_LAST - p]) begin
					if (p < rescl_pkg::PIX_LAST) begin
						rf  = 1'b1;
						rgt = p;
					end
					break;
				end
			end
			for (p = s - 1; p >= 0; p--) begin
				if (pix[rescl_pkg::PIX_LAST - p]) begin
					if (p > 0) begin
						lf  = 1'b1;
						lft = p;
					end
					break;
				end
			end
		end

		// Rebuild a lost edge from the stored half width
		if (lf && rf) begin
			if (in_rng)
				halfw_tab[row] = 6'((rgt - lft) / 2);
		end else if (rf) begin
			lft = rgt - 2 * hw;
		end else if (lf) begin
			rgt = lft + 2 * hw;
		end else begin
			lft = 0;
			rgt = rescl_pkg::PIX_LAST;
		end

		sum = lft + rgt;
		mid = (sum < 0) ? 0 : sum / 2;
		if (mid > rescl_pkg::PIX_LAST)
			mid = rescl_pkg::PIX_LAST;
		if (in_rng)
			centre_tab[row] = 7'(mid);

		want.centre      = 7'(mid);
		want.steer       = 7'(mid - rescl_pkg::PIX_MID);
		want.left_found  = lf;
		want.right_found = rf;
		results_due.push_back(want);
	endfunction

	// Compare one output beat with the oldest queued result
	function void check_result(logic [15:0] beat);
		centre_result_t want;
		bit             bad;
		beats_seen++;
		if (results_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("beat %0d: output %h arrived with no row pending", beats_seen, beat);
			return;
		end
		want = results_due.pop_front();
		bad = (beat[6:0] !== want.centre) || (beat[13:7] !== want.steer) ||
			(beat[14] !== want.left_found) || (beat[15] !== want.right_found);
		if (bad) begin
			mismatches++;
			if (mismatches <= 10)
				$display("beat %0d: centre %0d/%0d steer %0d/%0d left %b/%b right %b/%b (exp/got)",
					beats_seen, want.centre, beat[6:0], $signed(want.steer),
					$signed(beat[13:7]), want.left_found, beat[14],
					want.right_found, beat[15]);
		end
	endfunction
endclass

module testbench;
	localparam int ROWS       = rescl_pkg::ROWS_DEF;
	localparam int ROW_ITEMS  = 1200;
	localparam int STALL_LIMIT = 4000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [87:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;

	row_scan_scoreboard sb = new();

	int rx_mode, rx_left, rx_period, rx_phase;
	int burst_left;

	row_edge_scan_centerline_top #(.ROWS(ROWS)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	// Build a row with black bands ending at lcol (going left) and starting at rcol
	function automatic logic [79:0] track_row(int lcol, int rcol, int thick);
		logic [79:0] pix;
		int          k;
		pix = '0;
		for (k = 0; k < thick; k++) begin
			if (lcol - k >= 0 && lcol - k <= 79)
				pix[79 - (lcol - k)] = 1'b1;
			if (rcol + k >= 0 && rcol + k <= 79 && rcol >= 0)
				pix[79 - (rcol + k)] = 1'b1;
		end
		return pix;
	endfunction

	// Mostly tracks with a left and a right edge and random geometry, the rest noise and extremes
	function automatic logic [79:0] random_row();
		logic [79:0] pix;
		int          kind, c, w, l, r;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			c = $urandom_range(0, 79);
			w = $urandom_range(1, 38);
			l = c - w;
			r = c + w;
			if ($urandom_range(0, 5) == 0)
				l = -1;
			if ($urandom_range(0, 5) == 0)
				r = -1;
			pix = track_row(l, r, $urandom_range(1, 4));
			if ($urandom_range(0, 7) == 0)
				pix[$urandom_range(0, 79)] = 1'b1;
		end else if (kind < 88) begin
			pix[79:48] = $urandom;
			pix[47:16] = $urandom;
			pix[15:0]  = 16'($urandom_range(0, 65535));
		end else if (kind < 94) begin
			pix = '0;
			pix[$urandom_range(0, 79)] = 1'b1;
		end else begin
			pix = '1;
			pix[$urandom_range(0, 79)] = 1'b0;
		end
		return pix;
	endfunction

	function automatic logic [5:0] random_row_index();
		if ($urandom_range(0, 19) == 0)
			return 6'($urandom_range(ROWS, 63));
		return 6'($urandom_range(0, ROWS - 1));
	endfunction

	// Offer one row and hold it until the block takes the beat
	task automatic send_row(logic [5:0] row, logic [79:0] pix);
		@(negedge clk);
		s_tdata  = {2'b00, pix[15:0], pix[79:16], row};
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_row(row, pix);
	endtask

	task automatic idle_for(int cycles);
		@(negedge clk);
		s_tvalid = 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Receiver: switch between always ready, random, periodic and mostly stalled
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode   = $urandom_range(0, 3);
			rx_left   = $urandom_range(20, 200);
			rx_period = $urandom_range(2, 9);
		end else begin
			rx_left--;
		end
		rx_phase++;
		case (rx_mode)
			0: m_tready = 1'b1;
			1: m_tready = 1'($urandom_range(0, 1));
			2: m_tready = (rx_phase % rx_period) != 0;
			default: m_tready = ($urandom_range(0, 3) == 0);
		endcase
	end

	// Check every output beat
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// Watchdog: give up after a long stretch with no beat on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	initial begin
		int n;
		clk        = 1'b0;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		rx_mode    = 0;
		rx_left    = 0;
		rx_period  = 2;
		rx_phase   = 0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows: first row, edge rebuilds, clamps, lost edges, out-of-range rows
		send_row(6'd0,  '0);
		send_row(6'd0,  track_row(30, 50, 1));
		send_row(6'd0,  track_row(20, -1, 2));
		send_row(6'd0,  track_row(-1, 45, 1));
		send_row(6'd1,  track_row(39, 60, 1));
		send_row(6'd1,  track_row(10, 79, 1));
		send_row(6'd2,  track_row(0, 60, 1));
		send_row(6'd3,  track_row(-1, 41, 1));
		send_row(6'd3,  track_row(-1, 20, 1));
		send_row(6'd4,  track_row(70, -1, 1));
		send_row(6'd4,  track_row(78, -1, 1));
		send_row(6'd4,  '1);
		send_row(6'd5,  '0);
		send_row(6'd59, track_row(5, 74, 3));
		send_row(6'd60, track_row(10, 70, 1));
		send_row(6'd63, '0);
		send_row(6'd62, track_row(30, -1, 1));
		send_row(6'd61, {5{16'h5555}});
		send_row(6'd59, track_row(1, 78, 1));
		send_row(6'd6,  {5{16'hAAAA}});
		send_row(6'd59, {64'h0, 16'hFFFF});
		send_row(6'd7,  {64'hFFFF_FFFF_FFFF_FFFF, 16'h0});
		wait_drained();

		// Random rows in bursts, with one full drain halfway
		for (n = 0; n < ROW_ITEMS; n++) begin
			if (burst_left == 0) begin
				idle_for($urandom_range(1, 12));
				burst_left = $urandom_range(1, 40);
			end
			burst_left--;
			if (n == ROW_ITEMS / 2)
				wait_drained();
			send_row(random_row_index(), random_row());
		end

		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/rescl_pkg.sv
hw/rtl/rescl_lane.sv
hw/rtl/rescl_merge.sv
hw/rtl/row_edge_scan_centerline_top.sv
hw/rtl/rescl_chk.sv
bench/testbench.sv
